>>> hdl/segx_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared type for the stage handshake of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segx_pkg;

    typedef struct packed {
        logic valid;
        logic hit;
    } stage_flags_t;

endpackage

>>> hdl/segx_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Differences, cross products, determinant sign fold and range tests.
// ----------------------------------------------------------------------------
module segx_front #(
    parameter int W  = 32,
    parameter int DW = W + 1,
    parameter int PW = 2 * DW,
    parameter int KW = PW + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [W-1:0]  a_x,
    input  logic signed [W-1:0]  a_y,
    input  logic signed [W-1:0]  b_x,
    input  logic signed [W-1:0]  b_y,
    input  logic signed [W-1:0]  c_x,
    input  logic signed [W-1:0]  c_y,
    input  logic signed [W-1:0]  d_x,
    input  logic signed [W-1:0]  d_y,
    output segx_pkg::stage_flags_t out_flags,
    input  logic                 out_ready,
    output logic signed [W-1:0]  out_ax,
    output logic signed [W-1:0]  out_ay,
    output logic signed [DW-1:0] out_bxa,
    output logic signed [DW-1:0] out_bya,
    output logic [KW-1:0]        out_kmag,
    output logic [KW-1:0]        out_rn
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic a1, a2, a3, a4, a5;

    logic signed [W-1:0]  ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [W-1:0]  ax4_reg, ay4_reg, ax5_reg, ay5_reg;
    logic signed [DW-1:0] bxa1_reg, bya1_reg, axc1_reg, ayc1_reg, dxc1_reg, dyc1_reg;
    logic signed [DW-1:0] bxa2_reg, bya2_reg, bxa3_reg, bya3_reg;
    logic signed [DW-1:0] bxa4_reg, bya4_reg, bxa5_reg, bya5_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [KW-1:0] k3_reg, rn3_reg, sn3_reg;
    logic signed [KW-1:0] k4_reg, rn4_reg, sn4_reg;
    logic                 nz4_reg;
    logic signed [KW-1:0] k4_next, rn4_next, sn4_next;
    logic                 hit5_reg, hit5_next;
    logic [KW-1:0]        k5_reg, rn5_reg;

    assign a5       = !v5_reg || out_ready;
    assign a4       = !v4_reg || a5;
    assign a3       = !v3_reg || a4;
    assign a2       = !v2_reg || a3;
    assign a1       = !v1_reg || a2;
    assign in_ready = a1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (a1) v1_reg <= in_valid;
            if (a2) v2_reg <= v1_reg;
            if (a3) v3_reg <= v2_reg;
            if (a4) v4_reg <= v3_reg;
            if (a5) v5_reg <= v4_reg;
        end
    end

    always_comb begin
        if (k3_reg < 0) begin
            k4_next  = -k3_reg;
            rn4_next = -rn3_reg;
            sn4_next = -sn3_reg;
        end else begin
            k4_next  = k3_reg;
            rn4_next = rn3_reg;
            sn4_next = sn3_reg;
        end
        hit5_next = nz4_reg && (rn4_reg >= 0) && (sn4_reg >= 0)
                    && (rn4_reg <= k4_reg) && (sn4_reg <= k4_reg);
    end

    always_ff @(posedge aclk) begin
        if (a1) begin
            ax1_reg  <= a_x;
            ay1_reg  <= a_y;
            bxa1_reg <= DW'(b_x) - DW'(a_x);
            bya1_reg <= DW'(b_y) - DW'(a_y);
            axc1_reg <= DW'(a_x) - DW'(c_x);
            ayc1_reg <= DW'(a_y) - DW'(c_y);
            dxc1_reg <= DW'(d_x) - DW'(c_x);
            dyc1_reg <= DW'(d_y) - DW'(c_y);
        end
        if (a2) begin
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            bxa2_reg <= bxa1_reg;
            bya2_reg <= bya1_reg;
            p1_reg   <= PW'(bxa1_reg) * PW'(dyc1_reg);
            p2_reg   <= PW'(bya1_reg) * PW'(dxc1_reg);
            p3_reg   <= PW'(ayc1_reg) * PW'(dxc1_reg);
            p4_reg   <= PW'(axc1_reg) * PW'(dyc1_reg);
            p5_reg   <= PW'(ayc1_reg) * PW'(bxa1_reg);
            p6_reg   <= PW'(axc1_reg) * PW'(bya1_reg);
        end
        if (a3) begin
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bxa3_reg <= bxa2_reg;
            bya3_reg <= bya2_reg;
            k3_reg   <= KW'(p1_reg) - KW'(p2_reg);
            rn3_reg  <= KW'(p3_reg) - KW'(p4_reg);
            sn3_reg  <= KW'(p5_reg) - KW'(p6_reg);
        end
        if (a4) begin
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            bxa4_reg <= bxa3_reg;
            bya4_reg <= bya3_reg;
            nz4_reg  <= (k3_reg != '0);
            k4_reg   <= k4_next;
            rn4_reg  <= rn4_next;
            sn4_reg  <= sn4_next;
        end
        if (a5) begin
            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            bxa5_reg <= bxa4_reg;
            bya5_reg <= bya4_reg;
            hit5_reg <= hit5_next;
            k5_reg   <= k4_reg;
            rn5_reg  <= rn4_reg;
        end
    end

    assign out_flags.valid = v5_reg;
    assign out_flags.hit   = hit5_reg;
    assign out_ax          = ax5_reg;
    assign out_ay          = ay5_reg;
    assign out_bxa         = bxa5_reg;
    assign out_bya         = bya5_reg;
    assign out_kmag        = k5_reg;
    assign out_rn          = rn5_reg;

endmodule

>>> hdl/segx_div.sv
// ----------------------------------------------------------------------------
// Segment intersection ratio divider
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module segx_div #(
    parameter int KW  = 67,
    parameter int QW  = 25,
    parameter int SBW = 131
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [KW-1:0]   in_kmag,
    input  logic [KW-1:0]   in_rem,
    input  logic [SBW-1:0]  in_side,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [QW-1:0]   out_q,
    output logic [SBW-1:0]  out_side
);

    logic            v_reg    [QW];
    logic [KW-1:0]   k_reg    [QW];
    logic [KW-1:0]   rem_reg  [QW];
    logic [QW-1:0]   q_reg    [QW];
    logic [SBW-1:0]  side_reg [QW];
    logic            adv      [QW+1];

    assign adv[QW]  = out_ready;
    assign in_ready = adv[0];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic            vin;
        logic [KW-1:0]   kin, rin;
        logic [QW-1:0]   qin;
        logic [SBW-1:0]  sin;
        logic [KW:0]     trial;
        logic            ge;

        if (j == 0) begin : g_first
            assign vin   = in_valid;
            assign kin   = in_kmag;
            assign rin   = in_rem;
            assign qin   = '0;
            assign sin   = in_side;
            assign trial = {1'b0, rin};
        end else begin : g_rest
            assign vin   = v_reg[j-1];
            assign kin   = k_reg[j-1];
            assign rin   = rem_reg[j-1];
            assign qin   = q_reg[j-1];
            assign sin   = side_reg[j-1];
            assign trial = {rin, 1'b0};
        end

        assign ge     = trial >= {1'b0, kin};
        assign adv[j] = !v_reg[j] || adv[j+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                v_reg[j] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j]) begin
                k_reg[j]    <= kin;
                rem_reg[j]  <= ge ? KW'(trial - {1'b0, kin}) : KW'(trial);
                q_reg[j]    <= {qin[QW-2:0], ge};
                side_reg[j] <= sin;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

>>> hdl/segx_back.sv
// ----------------------------------------------------------------------------
// Segment intersection back end
// Scales the first segment by the ratio and adds its start point; a miss gives a zero point.
// ----------------------------------------------------------------------------
module segx_back #(
    parameter int W  = 32,
    parameter int F  = 24,
    parameter int DW = W + 1,
    parameter int QW = F + 1,
    parameter int OW = DW + QW + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_hit,
    input  logic signed [W-1:0]  in_ax,
    input  logic signed [W-1:0]  in_ay,
    input  logic signed [DW-1:0] in_bxa,
    input  logic signed [DW-1:0] in_bya,
    input  logic [QW-1:0]        in_q,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_hit,
    output logic [W-1:0]         out_x,
    output logic [W-1:0]         out_y
);

    logic                 va_reg, vb_reg, aa, ab;
    logic                 hita_reg, hitb_reg;
    logic signed [W-1:0]  axa_reg, aya_reg;
    logic signed [OW-1:0] oxa_reg, oya_reg;
    logic signed [OW-1:0] qs;
    logic signed [OW-1:0] oxs, oys;
    logic [W-1:0]         xb_reg, yb_reg;

    assign ab       = !vb_reg || out_ready;
    assign aa       = !va_reg || ab;
    assign in_ready = aa;
    assign qs       = OW'({1'b0, in_q});
    assign oxs      = oxa_reg >>> F;
    assign oys      = oya_reg >>> F;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (aa) va_reg <= in_valid;
            if (ab) vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (aa) begin
            hita_reg <= in_hit;
            axa_reg  <= in_ax;
            aya_reg  <= in_ay;
            oxa_reg  <= OW'(in_bxa) * qs;
            oya_reg  <= OW'(in_bya) * qs;
        end
        if (ab) begin
            hitb_reg <= hita_reg;
            xb_reg   <= hita_reg ? W'(axa_reg + oxs[W-1:0]) : '0;
            yb_reg   <= hita_reg ? W'(aya_reg + oys[W-1:0]) : '0;
        end
    end

    assign out_valid = vb_reg;
    assign out_hit   = hitb_reg;
    assign out_x     = xb_reg;
    assign out_y     = yb_reg;

endmodule

>>> hdl/segment_intersection_core.sv
// ----------------------------------------------------------------------------
// A beat runs from input to result through five front stages, one divider
// stage per quotient bit and two scaling stages.
// Throughput is one beat per cycle while the output is not stalled; a stalled output holds, and bubbles close.
// Reset (aresetn low, synchronous) empties every stage.
// ----------------------------------------------------------------------------
// Segment intersection core
// Tests two 2D segments for a crossing and gives the crossing point.
// ----------------------------------------------------------------------------
module segment_intersection_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int RATIO_FRAC_BITS = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up.
    input  logic [((8 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, cross_x, cross_y from the lowest bit up, zero padded.
    output logic [((2 * COORD_WIDTH + 8) / 8) * 8 - 1:0] m_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int KW  = 2 * DW + 1;
    localparam int QW  = RATIO_FRAC_BITS + 1;
    localparam int SBW = 1 + 2 * W + 2 * DW;
    localparam int OTW = ((2 * COORD_WIDTH + 8) / 8) * 8;

    segx_pkg::stage_flags_t front_flags;
    logic                 front_ready, div_valid, div_ready;
    logic signed [W-1:0]  f_ax, f_ay;
    logic signed [DW-1:0] f_bxa, f_bya;
    logic [KW-1:0]        f_kmag, f_rn;
    logic [SBW-1:0]       side_in, side_out;
    logic [QW-1:0]        div_q;
    logic                 b_hit;
    logic [W-1:0]         b_x, b_y;

    segx_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .a_x       (s_tdata[0*W +: W]),
        .a_y       (s_tdata[1*W +: W]),
        .b_x       (s_tdata[2*W +: W]),
        .b_y       (s_tdata[3*W +: W]),
        .c_x       (s_tdata[4*W +: W]),
        .c_y       (s_tdata[5*W +: W]),
        .d_x       (s_tdata[6*W +: W]),
        .d_y       (s_tdata[7*W +: W]),
        .out_flags (front_flags),
        .out_ready (front_ready),
        .out_ax    (f_ax),
        .out_ay    (f_ay),
        .out_bxa   (f_bxa),
        .out_bya   (f_bya),
        .out_kmag  (f_kmag),
        .out_rn    (f_rn)
    );

    assign side_in = {front_flags.hit, f_ax, f_ay, f_bxa, f_bya};

    segx_div #(.KW(KW), .QW(QW), .SBW(SBW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_flags.valid),
        .in_ready  (front_ready),
        .in_kmag   (f_kmag),
        .in_rem    (f_rn),
        .in_side   (side_in),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_q     (div_q),
        .out_side  (side_out)
    );

    segx_back #(.W(W), .F(RATIO_FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_hit    (side_out[SBW-1]),
        .in_ax     (side_out[2*DW + W +: W]),
        .in_ay     (side_out[2*DW +: W]),
        .in_bxa    (side_out[DW +: DW]),
        .in_bya    (side_out[0 +: DW]),
        .in_q      (div_q),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (b_hit),
        .out_x     (b_x),
        .out_y     (b_y)
    );

    assign m_tdata = OTW'({b_y, b_x, b_hit});

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result beat valid right after reset.");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while the output stage is empty.");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2*W:1] == '0))
        else $error("Miss beat carries a nonzero point.");

endmodule

>>> test/segment_intersection_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection checker
// Watches both stream channels of the segment intersection core, predicts the
// hit flag and crossing point of every accepted input beat with exact wide
// arithmetic, and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module segment_intersection_checker #(
    parameter int COORD_WIDTH     = 32,
    parameter int RATIO_FRAC_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [8*COORD_WIDTH-1:0]     s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [((2*COORD_WIDTH+8)/8)*8-1:0] m_tdata,
    output int                           fail_count,
    output int                           pending
);

    typedef struct packed {
        logic                   hit;
        logic [COORD_WIDTH-1:0] cross_x;
        logic [COORD_WIDTH-1:0] cross_y;
    } crossing_t;

    crossing_t crossings_due[$];

    function automatic crossing_t predict_crossing(input logic [8*COORD_WIDTH-1:0] seg);
        logic signed [191:0] ax, ay, bx, by, cx, cy, dx, dy;
        logic signed [191:0] bxa, bya, axc, ayc, dxc, dyc, det, rn, sn, ox, oy;
        logic [191:0] quot;
        crossing_t res;
        ax = $signed(seg[0*COORD_WIDTH +: COORD_WIDTH]);
        ay = $signed(seg[1*COORD_WIDTH +: COORD_WIDTH]);
        bx = $signed(seg[2*COORD_WIDTH +: COORD_WIDTH]);
        by = $signed(seg[3*COORD_WIDTH +: COORD_WIDTH]);
        cx = $signed(seg[4*COORD_WIDTH +: COORD_WIDTH]);
        cy = $signed(seg[5*COORD_WIDTH +: COORD_WIDTH]);
        dx = $signed(seg[6*COORD_WIDTH +: COORD_WIDTH]);
        dy = $signed(seg[7*COORD_WIDTH +: COORD_WIDTH]);
        bxa = bx - ax;
        bya = by - ay;
        axc = ax - cx;
        ayc = ay - cy;
        dxc = dx - cx;
        dyc = dy - cy;
        det = bxa * dyc - bya * dxc;
        rn = ayc * dxc - axc * dyc;
        sn = ayc * bxa - axc * bya;
        res = '0;
        if (det != 0) begin
            if (det < 0) begin
                det = -det;
                rn = -rn;
                sn = -sn;
            end
            if (rn >= 0 && sn >= 0 && rn <= det && sn <= det) begin
                quot = $unsigned(rn <<< RATIO_FRAC_BITS) / $unsigned(det);
                ox = (bxa * $signed(quot)) >>> RATIO_FRAC_BITS;
                oy = (bya * $signed(quot)) >>> RATIO_FRAC_BITS;
                res.hit = 1'b1;
                res.cross_x = ax[COORD_WIDTH-1:0] + ox[COORD_WIDTH-1:0];
                res.cross_y = ay[COORD_WIDTH-1:0] + oy[COORD_WIDTH-1:0];
            end
        end
        return res;
    endfunction

    assign pending = crossings_due.size();

    always @(posedge aclk) begin
        crossing_t want, got;
        if (!aresetn) begin
            crossings_due.delete();
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.hit = m_tdata[0];
                got.cross_x = m_tdata[1 +: COORD_WIDTH];
                got.cross_y = m_tdata[1+COORD_WIDTH +: COORD_WIDTH];
                if (crossings_due.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = crossings_due.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch expected hit=%0b x=%h y=%h actual hit=%0b x=%h y=%h",
                                 $time, want.hit, want.cross_x, want.cross_y,
                                 got.hit, got.cross_x, got.cross_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                crossings_due.push_back(predict_crossing(s_tdata));
        end
    end

endmodule

>>> test/segment_intersection_core_tb.sv
// ----------------------------------------------------------------------------
// Segment intersection core testbench
// Drives directed and random segment pairs through the core under varying
// sender and receiver idling and back pressure; a checker module predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module segment_intersection_core_tb;

    localparam int CW = 32;
    localparam int RFB = 24;
    localparam int LATENCY = RFB + 8;
    localparam int CYCLE_LIMIT = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [8*CW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [((2*CW+8)/8)*8-1:0] m_tdata;
    int fail_count;
    int pending;
    int send_idle_pct = 12;
    int recv_idle_pct = 59;
    bit start_hold = 1'b0;
    bit hold_off = 1'b0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    segment_intersection_core #(.COORD_WIDTH(CW), .RATIO_FRAC_BITS(RFB)) DUT (.*);

    segment_intersection_checker #(.COORD_WIDTH(CW), .RATIO_FRAC_BITS(RFB)) checker_i (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .fail_count, .pending
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {{(CW-20){1'b0}}, 20'($urandom)} - (1 << 19);
            2: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed(16'($urandom)) * 256);
        endcase
    endfunction

    task automatic send_pair(input logic [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dy, dx, cy, cx, by, bx, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_pair();
        logic [CW-1:0] p [8];
        foreach (p[i]) p[i] = rand_coord();
        if ($urandom_range(3) == 0) begin
            p[4] = p[0];
            p[5] = p[1];
        end else if ($urandom_range(7) == 0) begin
            p[6] = p[4] + (p[2] - p[0]);
            p[7] = p[5] + (p[3] - p[1]);
        end
        send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    localparam logic [CW-1:0] ONE = 32'h0001_0000;
    localparam logic [CW-1:0] TWO = 32'h0002_0000;
    localparam logic [CW-1:0] MAXC = 32'h7fff_ffff;
    localparam logic [CW-1:0] MINC = 32'h8000_0000;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_pair(0, 0, TWO, TWO, 0, TWO, TWO, 0);
        send_pair(0, 0, TWO, 0, 0, ONE, TWO, ONE);
        send_pair(0, 0, TWO, 0, ONE, 0, 3 * ONE, 0);
        send_pair(ONE, ONE, ONE, ONE, 0, 0, TWO, TWO);
        send_pair(0, 0, TWO, 0, TWO, 0, TWO, TWO);
        send_pair(0, 0, TWO, 0, 0, 0, 0, TWO);
        send_pair(0, 0, TWO, 0, ONE, ONE, ONE, TWO);
        send_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
        send_pair(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
        send_pair(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
        send_pair(MAXC, MAXC, MINC, MINC, 0, MINC, 0, MAXC);
        send_pair(0, 0, 3, 7, 0, 5, 3, 0);
        send_pair('1, '1, 0, 0, 0, '1, '1, 0);
        for (int n = 0; n < 600; n++) send_random_pair();
        send_idle_pct = 59;
        recv_idle_pct = 12;
        start_hold = 1'b1;
        for (int n = 0; n < 120; n++) send_random_pair();
        drain();
        for (int n = 0; n < 600; n++) send_random_pair();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 500; n++) send_random_pair();
        drain();
        repeat (LATENCY + 4) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        @(posedge start_hold);
        hold_off <= 1'b1;
        repeat (300) @(posedge aclk);
        hold_off <= 1'b0;
    end

endmodule

>>> files.f
hdl/segx_pkg.sv
hdl/segx_front.sv
hdl/segx_div.sv
hdl/segx_back.sv
hdl/segment_intersection_core.sv
test/segment_intersection_checker.sv
test/segment_intersection_core_tb.sv
